// File: rtl/lpht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

  // Default geometry of the table
  localparam int SLOTS_DEF      = 256;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 64;

  // Hash word, folded into the start slot one digit per cycle when SLOTS is not a power of two
  localparam int HASH_W      = 32;
  localparam int DIGIT_W     = 8;
  localparam int HASH_DIGITS = HASH_W / DIGIT_W;

  // Fill limit register
  localparam int                    MAX_FILL_W   = 9;
  localparam logic [MAX_FILL_W-1:0] MAX_FILL_RST = 9'd192;

  // Operation codes
  typedef enum logic [1:0] {
    OP_SET = 2'd0,
    OP_GET = 2'd1,
    OP_DEL = 2'd2,
    OP_NOP = 2'd3
  } op_t;

  // Slot status codes
  localparam int ST_W = 2;
  typedef enum logic [ST_W-1:0] {
    ST_EMPTY = 2'd0,
    ST_USED  = 2'd1,
    ST_TOMB  = 2'd2
  } slot_st_t;

endpackage

`default_nettype wire

// File: rtl/lpht_slot_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module lpht_slot_ram #(
  parameter int DEPTH = lpht_pkg::SLOTS_DEF,
  parameter int WIDTH = lpht_pkg::ST_W
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, read one entry with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/linear_probe_hash_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Items are handled one at a time: accept, fold the hash into the start slot (only when SLOTS is
// not a power of two), start, then probe P slots (P = 1..SLOTS, one memory read each) and commit;
// a no-op or a get/delete on an empty table goes from accept straight to commit. Commit waits while
// out_stall holds the last result; the next item is accepted while a result waits downstream.
// Reset: synchronous; fill limit 192, fill count zero, then a clearing pass writes every status
// entry empty with in_stall high.

module linear_probe_hash_table_unit #(
  parameter int SLOTS      = lpht_pkg::SLOTS_DEF,
  parameter int KEY_BITS   = lpht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lpht_pkg::VALUE_BITS_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // item channel
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire  [1:0]                      op,
  input  wire  [KEY_BITS-1:0]             key,
  input  wire  [lpht_pkg::HASH_W-1:0]     key_hash,
  input  wire  [VALUE_BITS-1:0]           value_in,
  // result channel
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            hit,
  output logic [VALUE_BITS-1:0]           value_out,
  output logic                            refused,
  // fill limit write channel
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [lpht_pkg::MAX_FILL_W-1:0] cfg_data
);

  localparam int  IDX_W      = $clog2(SLOTS);
  localparam int  CNT_W      = $clog2(SLOTS + 1);
  localparam bit  SLOTS_POW2 = (SLOTS & (SLOTS - 1)) == 0;
  localparam int  CMP_W      = ((CNT_W > lpht_pkg::MAX_FILL_W) ? CNT_W : lpht_pkg::MAX_FILL_W) + 1;
  localparam int  RED_W      = IDX_W + lpht_pkg::DIGIT_W;
  localparam int  DIG_CNT_W  = $clog2(lpht_pkg::HASH_DIGITS);
  localparam int  DATA_W     = KEY_BITS + VALUE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_REDUCE,
    S_START,
    S_PROBE,
    S_COMMIT
  } state_t;

  state_t                          state;
  logic [IDX_W-1:0]                clr_idx;
  lpht_pkg::op_t                   op_r;
  logic [KEY_BITS-1:0]             key_r;
  logic [VALUE_BITS-1:0]           val_r;
  logic [lpht_pkg::HASH_W-1:0]     hash_r;
  logic [IDX_W-1:0]                rem_r;
  logic [DIG_CNT_W-1:0]            dig_cnt;
  logic [IDX_W-1:0]                idx_r;
  logic [IDX_W-1:0]                cur;
  logic [IDX_W-1:0]                probe_n;
  logic                            have_tomb;
  logic [IDX_W-1:0]                tomb_idx;
  logic                            found_r;
  logic                            have_slot_r;
  logic                            slot_tomb_r;
  logic [IDX_W-1:0]                slot_r;
  logic [VALUE_BITS-1:0]           found_val;
  logic [CNT_W-1:0]                fill_count;
  logic [lpht_pkg::MAX_FILL_W-1:0] max_fill;

  // memory ports
  logic                            st_we;
  logic [IDX_W-1:0]                st_waddr;
  logic [lpht_pkg::ST_W-1:0]       st_wdata;
  logic [lpht_pkg::ST_W-1:0]       st_rdata;
  logic                            dat_we;
  logic [DATA_W-1:0]               dat_wdata;
  logic [DATA_W-1:0]               dat_rdata;
  logic [IDX_W-1:0]                rd_addr;

  // probe decode
  logic                            is_empty;
  logic                            is_used;
  logic                            is_match;
  logic                            is_tomb;
  logic                            probe_last;
  logic                            probe_done;
  logic [IDX_W-1:0]                next_idx;
  logic [KEY_BITS-1:0]             key_rd;
  logic [VALUE_BITS-1:0]           val_rd;

  // start slot fold
  logic [RED_W-1:0]                red;

  // commit decode
  logic                            out_free;
  logic                            over_limit;
  logic                            c_hit;
  logic                            c_refused;
  logic [VALUE_BITS-1:0]           c_vout;
  logic                            fill_inc;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;

  lpht_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (lpht_pkg::ST_W)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  lpht_slot_ram #(
    .DEPTH (SLOTS),
    .WIDTH (DATA_W)
  ) u_data_ram (
    .clk   (clk),
    .we    (dat_we),
    .waddr (slot_r),
    .wdata (dat_wdata),
    .raddr (rd_addr),
    .rdata (dat_rdata)
  );

  // Fold one hash digit into the running remainder modulo SLOTS
  always_comb begin
    red = {rem_r, hash_r[lpht_pkg::HASH_W-1 -: lpht_pkg::DIGIT_W]};
    for (int j = lpht_pkg::DIGIT_W - 1; j >= 0; j--) begin
      if (red >= (RED_W'(SLOTS) << j)) begin
        red = red - (RED_W'(SLOTS) << j);
      end
    end
  end

  // Decode the slot whose status and data arrive this cycle
  always_comb begin
    key_rd     = dat_rdata[DATA_W-1 -: KEY_BITS];
    val_rd     = dat_rdata[VALUE_BITS-1:0];
    is_empty   = st_rdata == lpht_pkg::ST_EMPTY;
    is_used    = st_rdata == lpht_pkg::ST_USED;
    is_match   = is_used && (key_rd == key_r);
    is_tomb    = !is_empty && !is_used;
    probe_last = probe_n == LAST_IDX;
    probe_done = is_empty || is_match || probe_last;
    next_idx   = (cur == LAST_IDX) ? '0 : cur + 1'b1;
    rd_addr    = (state == S_PROBE) ? next_idx : idx_r;
  end

  // Work out the result and the memory writes of the finished probe run, and the clearing writes
  always_comb begin
    over_limit = (CMP_W'(fill_count) + 1'b1) > CMP_W'(max_fill);
    c_hit      = 1'b0;
    c_refused  = 1'b0;
    c_vout     = '0;
    fill_inc   = 1'b0;
    st_we      = 1'b0;
    st_waddr   = slot_r;
    st_wdata   = lpht_pkg::ST_USED;
    dat_we     = 1'b0;
    dat_wdata  = {key_r, val_r};
    if (state == S_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_idx;
      st_wdata = lpht_pkg::ST_EMPTY;
    end else if (state == S_COMMIT && out_free) begin
      unique case (op_r)
        lpht_pkg::OP_SET: begin
          priority if (found_r) begin
            dat_we = 1'b1;
          end else if (!have_slot_r) begin
            c_refused = 1'b1;
          end else if (slot_tomb_r) begin
            st_we  = 1'b1;
            dat_we = 1'b1;
            c_hit  = 1'b1;
          end else if (over_limit) begin
            c_refused = 1'b1;
          end else begin
            st_we    = 1'b1;
            dat_we   = 1'b1;
            fill_inc = 1'b1;
            c_hit    = 1'b1;
          end
        end
        lpht_pkg::OP_GET: begin
          c_hit  = found_r;
          c_vout = found_r ? found_val : '0;
        end
        lpht_pkg::OP_DEL: begin
          c_hit    = found_r;
          st_we    = found_r;
          st_wdata = lpht_pkg::ST_TOMB;
        end
        lpht_pkg::OP_NOP: begin
          c_hit = 1'b0;
        end
      endcase
    end
  end

  // Sequencer: clear, accept, fold, probe, commit
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_idx    <= '0;
      out_valid  <= 1'b0;
      fill_count <= '0;
      max_fill   <= lpht_pkg::MAX_FILL_RST;
    end else begin
      if (cfg_valid) begin
        max_fill <= cfg_data;
      end
      // Raise the result word on commit, drop it once taken
      if (state == S_COMMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r        <= lpht_pkg::op_t'(op);
            key_r       <= key;
            val_r       <= value_in;
            hash_r      <= key_hash;
            rem_r       <= '0;
            dig_cnt     <= '0;
            found_r     <= 1'b0;
            have_slot_r <= 1'b0;
            slot_tomb_r <= 1'b0;
            priority if (lpht_pkg::op_t'(op) == lpht_pkg::OP_NOP ||
                         (lpht_pkg::op_t'(op) != lpht_pkg::OP_SET && fill_count == '0)) begin
              state <= S_COMMIT;
            end else if (SLOTS_POW2) begin
              idx_r <= key_hash[IDX_W-1:0];
              state <= S_START;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          rem_r   <= red[IDX_W-1:0];
          hash_r  <= hash_r << lpht_pkg::DIGIT_W;
          dig_cnt <= dig_cnt + 1'b1;
          if (dig_cnt == DIG_CNT_W'(lpht_pkg::HASH_DIGITS - 1)) begin
            idx_r <= red[IDX_W-1:0];
            state <= S_START;
          end
        end
        S_START: begin
          cur       <= idx_r;
          probe_n   <= '0;
          have_tomb <= 1'b0;
          state     <= S_PROBE;
        end
        S_PROBE: begin
          if (probe_done) begin
            found_r   <= is_match;
            found_val <= val_rd;
            priority if (is_empty) begin
              have_slot_r <= 1'b1;
              slot_r      <= have_tomb ? tomb_idx : cur;
              slot_tomb_r <= have_tomb;
            end else if (is_match) begin
              have_slot_r <= 1'b1;
              slot_r      <= cur;
              slot_tomb_r <= 1'b0;
            end else begin
              have_slot_r <= have_tomb || is_tomb;
              slot_r      <= have_tomb ? tomb_idx : cur;
              slot_tomb_r <= 1'b1;
            end
            state <= S_COMMIT;
          end else begin
            if (is_tomb && !have_tomb) begin
              have_tomb <= 1'b1;
              tomb_idx  <= cur;
            end
            cur     <= next_idx;
            probe_n <= probe_n + 1'b1;
          end
        end
        S_COMMIT: begin
          if (out_free) begin
            hit       <= c_hit;
            value_out <= c_vout;
            refused   <= c_refused;
            if (fill_inc) begin
              fill_count <= fill_count + 1'b1;
            end
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lpht_pkg::*;

  localparam int TABLE_SLOTS   = SLOTS_DEF;
  localparam int KEY_W         = KEY_BITS_DEF;
  localparam int VAL_W         = VALUE_BITS_DEF;
  localparam int POOL_KEYS     = 320;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 300;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] value;
    logic             refused;
  } reply_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            op;
  logic [KEY_W-1:0]      key;
  logic [HASH_W-1:0]     key_hash;
  logic [VAL_W-1:0]      value_in;
  logic                  out_valid;
  logic                  out_stall;
  logic                  hit;
  logic [VAL_W-1:0]      value_out;
  logic                  refused;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [MAX_FILL_W-1:0] cfg_data;

  int idle_pct;
  int stall_pct;
  int unsigned cycle_count = 0;
  int unsigned n_sent;

  logic [KEY_W-1:0]  pool_key  [POOL_KEYS];
  logic [HASH_W-1:0] pool_hash [POOL_KEYS];

  // Table shadow: predicts each reply and keeps the replies still owed by the block
  class hash_table_scoreboard;
    bit [KEY_W-1:0]      slot_key   [TABLE_SLOTS];
    bit [VAL_W-1:0]      slot_val   [TABLE_SLOTS];
    slot_st_t            slot_state [TABLE_SLOTS];
    int unsigned         used_count;
    bit [MAX_FILL_W-1:0] fill_limit;
    reply_t              expected_replies[$];
    int unsigned         errors;
    int unsigned         n_checked;
    int unsigned         n_hits;
    int unsigned         n_refused;

    function new();
      foreach (slot_state[i]) begin
        slot_state[i] = ST_EMPTY;
        slot_key[i]   = '0;
        slot_val[i]   = '0;
      end
      used_count = 0;
      fill_limit = MAX_FILL_RST;
      errors     = 0;
      n_checked  = 0;
      n_hits     = 0;
      n_refused  = 0;
    endfunction

    function void set_fill_limit(input bit [MAX_FILL_W-1:0] limit);
      fill_limit = limit;
    endfunction

    // Walk the probe run: stop on the key, on an empty slot, or after a full lap
    function void probe(input bit [KEY_W-1:0] k, input bit [HASH_W-1:0] h,
                        output bit found, output bit have_slot, output int unsigned slot);
      int unsigned idx;
      int unsigned tomb;
      bit          have_tomb;
      idx       = h % TABLE_SLOTS;
      tomb      = 0;
      have_tomb = 0;
      found     = 0;
      have_slot = 0;
      slot      = 0;
      for (int n = 0; n < TABLE_SLOTS; n++) begin
        if (slot_state[idx] == ST_EMPTY) begin
          have_slot = 1;
          slot      = have_tomb ? tomb : idx;
          return;
        end
        if (slot_state[idx] == ST_USED) begin
          if (slot_key[idx] == k) begin
            found     = 1;
            have_slot = 1;
            slot      = idx;
            return;
          end
        end else if (!have_tomb) begin
          have_tomb = 1;
          tomb      = idx;
        end
        idx = (idx + 1) % TABLE_SLOTS;
      end
      if (have_tomb) begin
        have_slot = 1;
        slot      = tomb;
      end
    endfunction

    // Apply one accepted operation to the shadow and queue its reply
    function void note_op(input op_t o, input bit [KEY_W-1:0] k, input bit [HASH_W-1:0] h,
                          input bit [VAL_W-1:0] v);
      reply_t      r;
      bit          found;
      bit          have_slot;
      int unsigned slot;
      r = '0;
      case (o)
        OP_SET: begin
          probe(k, h, found, have_slot, slot);
          if (found) begin
            slot_val[slot] = v;
          end else if (!have_slot) begin
            r.refused = 1'b1;
          end else if (slot_state[slot] == ST_TOMB) begin
            slot_state[slot] = ST_USED;
            slot_key[slot]   = k;
            slot_val[slot]   = v;
            r.hit            = 1'b1;
          end else if (used_count + 1 > fill_limit) begin
            r.refused = 1'b1;
          end else begin
            slot_state[slot] = ST_USED;
            slot_key[slot]   = k;
            slot_val[slot]   = v;
            used_count++;
            r.hit = 1'b1;
          end
        end
        OP_GET, OP_DEL: begin
          if (used_count != 0) begin
            probe(k, h, found, have_slot, slot);
            if (found) begin
              r.hit = 1'b1;
              if (o == OP_GET) r.value = slot_val[slot];
              else slot_state[slot] = ST_TOMB;
            end
          end
        end
        default: ;
      endcase
      expected_replies.push_back(r);
    endfunction

    // Compare one accepted result word with the oldest pending reply
    function void check_reply(input logic got_hit, input logic [VAL_W-1:0] got_value,
                              input logic got_refused);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("result word with no pending reply: hit=%0b value_out=%h refused=%0b",
               got_hit, got_value, got_refused);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      n_checked++;
      if (want.hit) n_hits++;
      if (want.refused) n_refused++;
      if (got_hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, got_hit);
        errors++;
      end
      if (got_value !== want.value) begin
        $error("value_out: expected %h, actual %h", want.value, got_value);
        errors++;
      end
      if (got_refused !== want.refused) begin
        $error("refused: expected %0b, actual %0b", want.refused, got_refused);
        errors++;
      end
    endfunction
  endclass

  hash_table_scoreboard sb;

  linear_probe_hash_table_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .key       (key),
    .key_hash  (key_hash),
    .value_in  (value_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .value_out (value_out),
    .refused   (refused),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Check each accepted result word, then pick the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) sb.check_reply(hit, value_out, refused);
      out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one operation word and hold it until the block takes it
  task automatic send_op(input op_t o, input logic [KEY_W-1:0] k, input logic [HASH_W-1:0] h,
                         input logic [VAL_W-1:0] v);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    op       <= o;
    key      <= k;
    key_hash <= h;
    value_in <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_op(o, k, h, v);
    n_sent++;
  endtask

  // Drop valid and wait for every pending reply
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_fill_limit(input logic [MAX_FILL_W-1:0] limit);
    cfg_valid <= 1'b1;
    cfg_data  <= limit;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_fill_limit(limit);
  endtask

  // Mostly pool keys with their own hash; some noise with stray keys, hashes and no-ops
  task automatic send_random(input int pool_n, input int set_pct, input int noise_pct);
    int               idx;
    int unsigned      r;
    op_t              o;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    v   = {$urandom, $urandom};
    if ($urandom_range(99) < 4) v = $urandom_range(1) ? '1 : '0;
    idx = $urandom_range(pool_n - 1);
    if ($urandom_range(99) < noise_pct) begin
      o = op_t'($urandom_range(3));
      k = $urandom_range(1) ? pool_key[idx] : $urandom;
      send_op(o, k, $urandom, v);
    end else begin
      r = $urandom_range(99);
      if (r < set_pct) o = OP_SET;
      else if (r < set_pct + (100 - set_pct) * 2 / 3) o = OP_GET;
      else o = OP_DEL;
      send_op(o, pool_key[idx], pool_hash[idx], v);
    end
  endtask

  task automatic pick_traffic(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 75; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 75; end
      default: begin idle_pct = 31; stall_pct = 31; end
    endcase
  endtask

  // One traffic phase at a fixed fill limit; hold off halfway until every pending reply is in
  task automatic run_phase(input int mode, input logic [MAX_FILL_W-1:0] limit, input int count,
                           input int pool_n, input int set_pct, input int noise_pct);
    wait_idle();
    write_fill_limit(limit);
    pick_traffic(mode);
    for (int i = 0; i < count; i++) begin
      if (mode > 3 && i % 25 == 0) pick_traffic($urandom_range(3));
      if (i == count / 2) wait_idle();
      send_random(pool_n, set_pct, noise_pct);
    end
  endtask

  initial begin
    logic [31:0] rnd;
    clk         = 1'b0;
    rst         = 1'b1;
    in_valid    = 1'b0;
    op          = OP_NOP;
    key         = '0;
    key_hash    = '0;
    value_in    = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    n_sent      = 0;
    sb          = new();

    // Unique keys; hashes bunched near slot 0 and the top of the table to force long runs
    for (int i = 0; i < POOL_KEYS; i++) begin
      rnd          = $urandom;
      pool_key[i]  = {rnd[31:9], 9'(i)};
      rnd          = $urandom;
      case (i % 4)
        0: rnd[7:0] = 8'($urandom_range(15));
        1: rnd[7:0] = 8'($urandom_range(255, 248));
        default: ;
      endcase
      pool_hash[i] = rnd;
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, wrap-around, overwrite, tombstones, no-ops
    send_op(OP_GET, '0, '0, '1);
    send_op(OP_DEL, '1, '1, '0);
    send_op(OP_NOP, '1, '1, '1);
    send_op(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(OP_SET, 32'h0000_0000, 32'h1234_56FF, 64'h0);
    send_op(OP_GET, 32'h0000_0000, 32'h1234_56FF, '0);
    send_op(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_op(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(OP_DEL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(OP_GET, 32'h0000_0000, 32'h1234_56FF, '0);
    send_op(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_op(OP_SET, 32'h8000_0001, 32'hAAAA_AAFF, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OP_DEL, 32'h8000_0001, 32'hAAAA_AAFF, '0);
    send_op(OP_DEL, 32'h8000_0001, 32'hAAAA_AAFF, '0);
    send_op(OP_SET, 32'h5555_5555, 32'h8000_0000, 64'h5555_5555_5555_5555);
    send_op(OP_GET, 32'h5555_5555, 32'h8000_0000, '0);

    // Directed: limit of one refuses empty-slot inserts but still allows reuse and overwrite
    wait_idle();
    write_fill_limit(9'd1);
    send_op(OP_SET, 32'h7777_0000, 32'h0000_0010, 64'hDEAD_BEEF_0000_0001);
    send_op(OP_GET, 32'h7777_0000, 32'h0000_0010, '0);
    send_op(OP_SET, 32'h1111_1111, 32'h0000_00FF, 64'h1111_2222_3333_4444);
    send_op(OP_GET, 32'h1111_1111, 32'h0000_00FF, '0);
    send_op(OP_SET, 32'h5555_5555, 32'h8000_0000, 64'hCAFE_F00D_CAFE_F00D);
    send_op(OP_NOP, '0, '0, '0);

    // Random phases; the fill count only grows, so limits rise over the first four phases, then a random one
    run_phase(0, 9'd24, 150, 40, 50, 5);
    run_phase(1, 9'($urandom_range(150, 60)), 200, 120, 55, 5);
    run_phase(2, MAX_FILL_RST, 200, 200, 55, 8);
    run_phase(3, 9'd256, 350, POOL_KEYS, 80, 3);
    run_phase(4, 9'($urandom_range(256, 1)), 200, POOL_KEYS, 45, 10);

    // Drain and let any stray word show up
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_replies.size() != 0) begin
      $error("%0d replies never arrived", sb.expected_replies.size());
      sb.errors++;
    end

    $display("Run covered %0d operations over five traffic phases, fill limits 1 to 256.",
             n_sent);
    $display("Checked %0d replies: %0d hits, %0d refused inserts.",
             sb.n_checked, sb.n_hits, sb.n_refused);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: linear_probe_hash_table_unit.f
rtl/lpht_pkg.sv
rtl/lpht_slot_ram.sv
rtl/linear_probe_hash_table_unit.sv
verif/tb_top.sv
